// ===== rtl/core/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Operation and status codes, field widths, and the entry and cell control
// structures that the cell row and the top level pass between them.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned GRADE_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_CNT_W = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [GRADE_W-1:0] THRESHOLD_RESET = 10'd700;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [GRADE_W-1:0]      grade;
    logic                    pass;
  } entry_t;

  // Broadcast to every cell: compare against the new key, shift for insert,
  // or shift for remove.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== rtl/core/skt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one entry, compares it against the broadcast key and shifts in from
// its left neighbor on insert or from its right neighbor on remove.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
#(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctl_t               ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic signed [KEY_W-1:0] cmp_key,
  input  entry_t                  new_ent,
  input  entry_t                  left_ent,
  input  entry_t                  right_ent,
  input  logic                    left_lt,
  output entry_t                  ent,
  output logic                    lt,
  output logic                    hit
);

  entry_t ent_r;
  logic   lt_r;
  logic   eq_r;
  logic   occ;

  assign occ = (CNT_W'(IDX) < count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp) begin
      lt_r <= occ && ($signed(ent_r.key) < cmp_key);
      eq_r <= occ && ($signed(ent_r.key) == cmp_key);
    end
  end

  // Entries below the insert/remove point hold; the rest move one slot.
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt_r) begin
      ent_r <= left_lt ? new_ent : left_ent;
    end else if (ctl.rem && !lt_r) begin
      ent_r <= right_ent;
    end
  end

  assign ent = ent_r;
  assign lt  = lt_r;
  // First matching slot: equal here, strictly less on the left.
  assign hit = eq_r && left_lt;

endmodule

// ===== rtl/core/sorted_key_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_top: sorted key table built from a row of shifting cells
// Keeps up to CAPACITY entries in ascending signed key order and serves
// insert, find, remove and clear, one result word per input word.
// ----------------------------------------------------------------------------
// On acceptance of an input word every cell registers its compare of the
// stored key against the new key. In the exec step that follows, held
// while the output register is full and stalled, the row shifts (right for
// insert, left for remove) and the result word is loaded into the output
// register. Input stalls during the exec step, so one word is in flight; a
// new input word is taken while the previous result still waits on the
// output. Insert places the entry ahead of the first entry whose key is not
// less, so the newest of duplicate keys comes first; on a full table it
// returns status full with the count unchanged. Find and remove act on the
// first entry with a matching key. Clear only resets the count. The user is
// to write pass_threshold through cfg_wr_en/cfg_wr_data while the block is
// idle; the block does not enforce this. entry_count is the count modulo 32.
// ----------------------------------------------------------------------------
module sorted_key_table_top
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [GRADE_W-1:0]      cfg_wr_data,
  // input words
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [GRADE_W-1:0]      in_grade,
  // result words
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [GRADE_W-1:0]      out_found_grade,
  output logic                    out_found_pass,
  output logic [OUT_CNT_W-1:0]    out_entry_count
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state_r;
  logic [FUNC_W-1:0]       func_r;
  logic signed [KEY_W-1:0] key_r;
  logic [GRADE_W-1:0]      grade_r;
  logic [GRADE_W-1:0]      thr_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     status_r;
  logic [STATUS_W-1:0]     status_nxt;
  logic [GRADE_W-1:0]      fgrade_r;
  logic [GRADE_W-1:0]      fgrade_nxt;
  logic                    fpass_r;
  logic                    fpass_nxt;

  logic                    in_acc;
  logic                    fire;
  logic                    full;
  logic                    hit_any;
  logic [GRADE_W-1:0]      hit_grade;
  logic                    hit_pass;
  cell_ctl_t               ctl;
  entry_t                  new_ent;
  logic [CNT_W+OUT_CNT_W-1:0] count_ext;

  entry_t                  ent_w [CAPACITY];
  logic [CAPACITY-1:0]     lt_w;
  logic [CAPACITY-1:0]     hit_w;

  // One word in flight; hold the exec step while a full result register stalls.
  assign in_stall = (state_r == S_EXEC);
  assign in_acc   = in_valid && !in_stall;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign full     = (count_r == CNT_W'(CAPACITY));

  assign new_ent.key   = key_r;
  assign new_ent.grade = grade_r;
  assign new_ent.pass  = (grade_r >= thr_r);

  // Compare on acceptance with the incoming key; shift on the exec step.
  assign ctl.cmp = in_acc;
  assign ctl.ins = fire && (func_r == FUNC_INSERT) && !full;
  assign ctl.rem = fire && (func_r == FUNC_REMOVE) && hit_any;

  // ---- row of cells ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_lt;

    if (i == 0) begin : g_first
      assign left_ent = new_ent;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent_w[i-1];
      assign left_lt  = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = ent_w[i];
    end else begin : g_inner
      assign right_ent = ent_w[i+1];
    end

    skt_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count_r),
      .cmp_key   (in_key),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .left_lt   (left_lt),
      .ent       (ent_w[i]),
      .lt        (lt_w[i]),
      .hit       (hit_w[i])
    );
  end

  // Gather the single matching slot, if any.
  always_comb begin
    hit_any   = 1'b0;
    hit_grade = '0;
    hit_pass  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_any   = hit_any | hit_w[i];
      hit_grade = hit_grade | (hit_w[i] ? ent_w[i].grade : '0);
      hit_pass  = hit_pass | (hit_w[i] & ent_w[i].pass);
    end
  end

  // Result word and new count for the exec step.
  always_comb begin
    status_nxt = ST_OK;
    fgrade_nxt = '0;
    fpass_nxt  = 1'b0;
    count_nxt  = count_r;
    case (func_r)
      FUNC_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_FIND, FUNC_REMOVE: begin
        if (hit_any) begin
          fgrade_nxt = hit_grade;
          fpass_nxt  = hit_pass;
          if (func_r == FUNC_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      FUNC_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      thr_r       <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand and result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_func;
      key_r   <= in_key;
      grade_r <= in_grade;
    end
    if (fire) begin
      status_r <= status_nxt;
      fgrade_r <= fgrade_nxt;
      fpass_r  <= fpass_nxt;
    end
  end

  assign count_ext       = {{OUT_CNT_W{1'b0}}, count_r};
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_grade = fgrade_r;
  assign out_found_pass  = fpass_r;
  assign out_entry_count = count_ext[OUT_CNT_W-1:0];

  // ---- assertions ----
  // At most one slot can be the first match.
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hit_w))
    else $error("more than one slot reports a first match");

  // The count never passes the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every exec step leaves a result word waiting.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("exec step produced no result word");

  // A refused insert only happens on a full table, and leaves it full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> full)
    else $error("full status reported on a table that is not full");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted key table
// Drives insert, find, remove and clear words through the valid/stall input
// channel. A small scoreboard keeps its own copy of the sorted table and
// predicts every result word, which the output monitor then checks field by
// field. The pass threshold moves through its extremes between phases.
// ----------------------------------------------------------------------------
module testbench;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned PHASE_WORDS  = 250;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned TAIL_TICKS   = 10;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned MAX_REPORTS  = 50;
  localparam time         TIMEOUT_NS   = 3_000_000;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  // One result word as the block presents it.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [GRADE_W-1:0]   grade;
    logic                 pass;
    logic [OUT_CNT_W-1:0] count;
  } table_reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a shadow copy of the table plus the queue of replies that
  // the accepted words have earned and that the block still owes.
  // --------------------------------------------------------------------------
  class key_table_scoreboard #(int unsigned DEPTH = 16);
    logic [GRADE_W-1:0]      threshold;
    logic signed [KEY_W-1:0] keys[DEPTH];
    logic [GRADE_W-1:0]      grades[DEPTH];
    logic                    pass_flags[DEPTH];
    int unsigned             count;
    table_reply_t            owed_replies[$];
    int unsigned             fail_count;
    int unsigned             checked;
    int unsigned             func_seen[4];
    int unsigned             full_seen;
    int unsigned             miss_seen;

    function new();
      threshold  = THRESHOLD_RESET;
      count      = 0;
      fail_count = 0;
      checked    = 0;
      full_seen  = 0;
      miss_seen  = 0;
      foreach (func_seen[i]) func_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    // Apply one accepted word to the shadow table and queue its reply.
    function void note_input(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                             logic [GRADE_W-1:0] grade);
      table_reply_t reply;
      int           pos;
      int           i;
      reply = '0;
      reply.status = ST_OK;
      func_seen[func]++;
      case (func)
        FUNC_INSERT: begin
          if (count >= DEPTH) begin
            reply.status = ST_FULL;
            full_seen++;
          end else begin
            // land ahead of the first key that is not less: the newest duplicate leads
            pos = 0;
            while (pos < int'(count) && keys[pos] < key) pos++;
            for (i = int'(count); i > pos; i--) begin
              keys[i]       = keys[i-1];
              grades[i]     = grades[i-1];
              pass_flags[i] = pass_flags[i-1];
            end
            keys[pos]       = key;
            grades[pos]     = grade;
            pass_flags[pos] = (grade >= threshold);
            count++;
          end
        end
        FUNC_FIND, FUNC_REMOVE: begin
          pos = int'(count);
          for (i = int'(count) - 1; i >= 0; i--) begin
            if (keys[i] == key) pos = i;
          end
          if (pos >= int'(count)) begin
            reply.status = ST_NOT_FOUND;
            miss_seen++;
          end else begin
            reply.grade = grades[pos];
            reply.pass  = pass_flags[pos];
            if (func == FUNC_REMOVE) begin
              for (i = pos; i + 1 < int'(count); i++) begin
                keys[i]       = keys[i+1];
                grades[i]     = grades[i+1];
                pass_flags[i] = pass_flags[i+1];
              end
              count--;
            end
          end
        end
        default: begin
          count = 0;
        end
      endcase
      reply.count = count[OUT_CNT_W-1:0];
      owed_replies.push_back(reply);
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(table_reply_t got);
      table_reply_t want;
      checked++;
      if (owed_replies.size() == 0) begin
        report_mismatch("result word arrived with nothing outstanding");
      end else begin
        want = owed_replies.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    checked, got.status, want.status));
        if (got.grade !== want.grade)
          report_mismatch($sformatf("reply %0d found_grade %0d, want %0d",
                                    checked, got.grade, want.grade));
        if (got.pass !== want.pass)
          report_mismatch($sformatf("reply %0d found_pass %0b, want %0b",
                                    checked, got.pass, want.pass));
        if (got.count !== want.count)
          report_mismatch($sformatf("reply %0d entry_count %0d, want %0d",
                                    checked, got.count, want.count));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, block and its ports
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [GRADE_W-1:0]      cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [FUNC_W-1:0]       in_func;
  logic signed [KEY_W-1:0] in_key;
  logic [GRADE_W-1:0]      in_grade;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_W-1:0]     out_status;
  logic [GRADE_W-1:0]      out_found_grade;
  logic                    out_found_pass;
  logic [OUT_CNT_W-1:0]    out_entry_count;

  key_table_scoreboard #(TABLE_DEPTH) sb;
  int unsigned thresholds_written;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_key_table_top #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_grade        (in_grade),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_grade (out_found_grade),
    .out_found_pass  (out_found_pass),
    .out_entry_count (out_entry_count)
  );

  // --------------------------------------------------------------------------
  // Driving tasks. Every call starts just after a rising edge; signals read
  // right after the edge still hold their pre-edge values, so a word counts
  // as accepted exactly when the block saw valid high and stall low.
  // --------------------------------------------------------------------------

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [FUNC_W-1:0] func, input logic signed [KEY_W-1:0] key,
                           input logic [GRADE_W-1:0] grade);
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    in_grade <= grade;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(func, key, grade);
  endtask

  // Drain the block, then write the threshold. Valid must already be low.
  task automatic write_threshold(input logic [GRADE_W-1:0] value);
    while (sb.pending() != 0) @(posedge clk);
    // give the row time to settle after the last reply
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.threshold = value;
    thresholds_written++;
  endtask

  // Build one random word. Half the keys come from the live table so find
  // and remove mostly hit; a small pool makes duplicates; the rest are the
  // key extremes or fully random bits.
  task automatic send_random_word(input int unsigned clear_pct);
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic [GRADE_W-1:0]      grade;
    int unsigned             pick;
    int                      near;
    pick = $urandom_range(0, 99);
    if (pick < clear_pct) func = FUNC_CLEAR;
    else if (pick < 50) func = FUNC_INSERT;
    else if (pick < 74) func = FUNC_FIND;
    else func = FUNC_REMOVE;

    pick = $urandom_range(0, 99);
    if (pick < 50 && sb.count > 0) begin
      key = sb.keys[$urandom_range(0, sb.count - 1)];
    end else if (pick < 80) begin
      key = int'($urandom_range(0, 15)) - 8;
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0: key = KEY_MIN;
        1: key = KEY_MAX;
        2: key = '0;
        default: key = '1;
      endcase
    end else begin
      key = $urandom;
    end

    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      grade = GRADE_W'($urandom_range(0, 1000));
    end else if (pick < 90) begin
      // straddle the pass threshold
      near = int'(sb.threshold) + int'($urandom_range(0, 4)) - 2;
      if (near < 0) near = 0;
      if (near > 1023) near = 1023;
      grade = near[GRADE_W-1:0];
    end else begin
      grade = GRADE_W'($urandom_range(1001, 1023));
    end
    send_word(func, key, grade);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: check every word the block hands over.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(table_reply_t'({out_status, out_found_grade, out_found_pass,
                                      out_entry_count}));
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on stretches of its own pattern. Twice in the run, hold
  // off for a long stretch so the row backs up and stalls the input side.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned holds_done;
    int unsigned stretch;
    int unsigned mode;
    holds_done = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < 2 && sb.checked >= (holds_done + 1) * 800) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        stretch = $urandom_range(8, 60);
        mode    = $urandom_range(0, 3);
        repeat (stretch) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 25);
            2: out_stall <= ($urandom_range(0, 99) < 60);
            default: out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed words, then random phases, each under a
  // fresh threshold written while the block is drained.
  // --------------------------------------------------------------------------
  initial begin
    logic [GRADE_W-1:0] phase_thresholds[PHASE_COUNT];
    int unsigned        burst_left;
    int unsigned        gap;
    int unsigned        fill_idx;
    sb = new();
    thresholds_written = 0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_func     <= FUNC_CLEAR;
    in_key      <= '0;
    in_grade    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset threshold.
    // Clear, find and remove on an empty table.
    send_word(FUNC_CLEAR, '0, '0);
    send_word(FUNC_FIND, '0, '0);
    send_word(FUNC_REMOVE, '0, '0);
    // Key and grade extremes, a duplicate pair on either side of the threshold.
    send_word(FUNC_INSERT, KEY_MIN, 10'd0);
    send_word(FUNC_INSERT, KEY_MAX, 10'd1023);
    send_word(FUNC_INSERT, 32'sd5, THRESHOLD_RESET - 10'd1);
    send_word(FUNC_INSERT, 32'sd5, THRESHOLD_RESET);
    send_word(FUNC_INSERT, -32'sd1, 10'd1000);
    // The later duplicate is found first and removed, then the earlier shows up.
    send_word(FUNC_FIND, 32'sd5, '0);
    send_word(FUNC_REMOVE, 32'sd5, '0);
    send_word(FUNC_FIND, 32'sd5, '0);
    send_word(FUNC_FIND, KEY_MAX, '0);
    send_word(FUNC_REMOVE, KEY_MIN, '0);
    // Fill to the top, then insert into a full table.
    fill_idx = 0;
    while (sb.count < TABLE_DEPTH) begin
      send_word(FUNC_INSERT, int'(fill_idx) * 3 - 20, 10'(650 + fill_idx * 9));
      fill_idx++;
    end
    send_word(FUNC_INSERT, 32'sd9, 10'd900);
    send_word(FUNC_FIND, 32'sd123456, '0);
    send_word(FUNC_CLEAR, '0, '0);
    in_valid <= 1'b0;

    // Threshold settings: extremes first, then random values.
    phase_thresholds[0] = 10'd0;
    phase_thresholds[1] = 10'd1023;
    phase_thresholds[2] = 10'd1000;
    phase_thresholds[3] = 10'd1;
    phase_thresholds[4] = THRESHOLD_RESET;
    for (int p = 5; p < PHASE_COUNT; p++)
      phase_thresholds[p] = GRADE_W'($urandom_range(0, 1023));

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // writing the threshold also waits out every owed reply
      write_threshold(phase_thresholds[p]);
      burst_left = 0;
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // roughly a third of bursts follow straight on
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        // odd phases clear rarely so the table fills and refuses inserts
        send_random_word((p % 2 == 1) ? 1 : 6);
        burst_left--;
      end
      in_valid <= 1'b0;
    end

    // Drain, then give the row time to show any stray word.
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_TICKS) @(posedge clk);

    $display("Covered %0d words (%0d insert, %0d find, %0d remove, %0d clear) over %0d thresholds.",
             sb.func_seen[FUNC_INSERT] + sb.func_seen[FUNC_FIND] +
             sb.func_seen[FUNC_REMOVE] + sb.func_seen[FUNC_CLEAR],
             sb.func_seen[FUNC_INSERT], sb.func_seen[FUNC_FIND],
             sb.func_seen[FUNC_REMOVE], sb.func_seen[FUNC_CLEAR], thresholds_written + 1);
    $display("Checked %0d replies: %0d full refusals, %0d key misses, %0d mismatches.",
             sb.checked, sb.full_seen, sb.miss_seen, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("[sorted_key_table_top] OK");
    end else begin
      $display("[sorted_key_table_top] ERROR");
    end
    $finish;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d replies outstanding.", sb.pending());
    $display("[sorted_key_table_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/sorted_key_table_top.sv
tb/sv/testbench.sv
